/* rtl/core/dersig_pkg.sv */
// Shared types and constants for the DER signature parser.
package dersig_pkg;

  localparam int unsigned INT_BYTES   = 32;
  localparam int unsigned STORE_BYTES = 2 * INT_BYTES;
  localparam int unsigned LANES       = 8;
  localparam int unsigned ROWS        = STORE_BYTES / LANES;

  localparam logic [7:0] SEQ_TAG     = 8'h30;
  localparam logic [7:0] INT_TAG     = 8'h02;
  localparam logic [7:0] SEQ_MAX     = 8'd70;
  localparam logic [7:0] INT_LEN_MAX = 8'(INT_BYTES + 1);

  typedef logic [$clog2(STORE_BYTES)-1:0] store_addr_t;
  typedef logic [$clog2(ROWS)-1:0]        row_t;

  // One queued word from the parser to the store/emitter.
  typedef struct packed {
    logic        wr_en;
    store_addr_t addr;
    logic [7:0]  data;
    logic        fin;
    logic        ok;
  } cmd_t;

endpackage

/* rtl/core/der_signature_parser_core.sv */
// Top level of the streaming DER ECDSA signature decoder.
//
// Input channel: one encoding byte per word (der_byte) with last on the final
// byte, moved when in_valid is high and in_stall is low. Output channel: after
// the last byte, eight 64-bit big-endian words of r||s (word_index 0..7,
// last_word on the eighth), moved when out_valid is high and out_stall low.
// status is 0 for a well-formed signature; on a malformed one every word is 0.
// Bytes are taken at one per cycle while in_stall is low; in_stall rises only
// when the command queue between parser and emitter is full, which happens
// while a message's words are being emitted. Each output word passes through
// the emitter's row read from the eight byte-lane RAMs, word assembly and
// hand-off, in that order. A stalled word holds. Synchronous reset clears the
// parser, the queue and the store valid bits; the store reads as zero after
// reset and after every message.
module der_signature_parser_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  der_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] sig_word,
  output logic [2:0]  word_index,
  output logic        status,
  output logic        last_word
);
  import dersig_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  cmd_t q_head;

  dersig_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .der_byte(der_byte),
    .last    (last),
    .q_full  (q_full),
    .push    (push),
    .cmd     (push_cmd)
  );

  dersig_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_valid),
    .head     (q_head)
  );

  dersig_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sig_word  (sig_word),
    .word_index(word_index),
    .status    (status),
    .last_word (last_word)
  );
endmodule

/* rtl/core/dersig_ram.sv */
// Generic single-port-write, registered-read RAM.
module dersig_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* rtl/core/dersig_front.sv */
// Byte parser: walks the DER structure and issues store writes and finish words.
module dersig_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        der_byte,
  input  logic              last,
  input  logic              q_full,
  output logic              push,
  output dersig_pkg::cmd_t  cmd
);
  import dersig_pkg::*;

  localparam logic [2:0] PH_SEQ_TAG   = 3'd0;
  localparam logic [2:0] PH_SEQ_LEN   = 3'd1;
  localparam logic [2:0] PH_INT_TAG   = 3'd2;
  localparam logic [2:0] PH_INT_LEN   = 3'd3;
  localparam logic [2:0] PH_INT_FIRST = 3'd4;
  localparam logic [2:0] PH_INT_BODY  = 3'd5;
  localparam logic [2:0] PH_DONE      = 3'd6;

  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  seq_len, seq_len_next;
  logic [2:0]  phase, phase_next;
  logic        int_num, int_num_next;
  logic [5:0]  bytes_left, bytes_left_next;
  store_addr_t write_index, write_index_next;
  logic        err, err_next;

  logic        accept;
  logic        fin_int;
  logic [7:0]  rem;
  store_addr_t half_end;
  store_addr_t wa;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign half_end = store_addr_t'({!int_num, 5'b0});

  always_comb begin
    byte_count_next  = byte_count;
    seq_len_next     = seq_len;
    phase_next       = phase;
    int_num_next     = int_num;
    bytes_left_next  = bytes_left;
    write_index_next = write_index;
    err_next         = err;
    fin_int          = 1'b0;
    rem              = '0;
    wa               = '0;
    cmd              = '0;
    if (accept) begin
      if (!err) begin
        unique case (phase)
          PH_SEQ_TAG: begin
            if (der_byte != SEQ_TAG) err_next = 1'b1;
            else phase_next = PH_SEQ_LEN;
          end
          PH_SEQ_LEN: begin
            if (der_byte > SEQ_MAX) begin
              err_next = 1'b1;
            end else begin
              seq_len_next = der_byte;
              phase_next   = PH_INT_TAG;
            end
          end
          PH_INT_TAG: begin
            rem             = (seq_len >= byte_count) ? seq_len - byte_count : 8'd0;
            byte_count_next = byte_count + 8'd1;
            if (rem < 8'd2 || der_byte != INT_TAG) err_next = 1'b1;
            else phase_next = PH_INT_LEN;
          end
          PH_INT_LEN: begin
            byte_count_next = byte_count + 8'd1;
            rem = (seq_len >= byte_count_next) ? seq_len - byte_count_next : 8'd0;
            if (der_byte > rem || der_byte > INT_LEN_MAX) begin
              err_next = 1'b1;
            end else if (der_byte == 8'd0) begin
              fin_int = 1'b1;
            end else begin
              bytes_left_next = der_byte[5:0];
              phase_next      = PH_INT_FIRST;
            end
          end
          PH_INT_FIRST: begin
            byte_count_next = byte_count + 8'd1;
            if (der_byte == 8'd0) begin
              bytes_left_next  = bytes_left - 6'd1;
              write_index_next = half_end - bytes_left_next;
              if (bytes_left_next == 6'd0) fin_int = 1'b1;
              else phase_next = PH_INT_BODY;
            end else if (bytes_left > 6'(INT_BYTES)) begin
              err_next = 1'b1;
            end else begin
              wa               = half_end - bytes_left;
              cmd.wr_en        = 1'b1;
              cmd.addr         = wa;
              cmd.data         = der_byte;
              write_index_next = wa + 6'd1;
              bytes_left_next  = bytes_left - 6'd1;
              if (bytes_left_next == 6'd0) fin_int = 1'b1;
              else phase_next = PH_INT_BODY;
            end
          end
          PH_INT_BODY: begin
            byte_count_next  = byte_count + 8'd1;
            cmd.wr_en        = 1'b1;
            cmd.addr         = write_index;
            cmd.data         = der_byte;
            write_index_next = write_index + 6'd1;
            bytes_left_next  = bytes_left - 6'd1;
            if (bytes_left_next == 6'd0) fin_int = 1'b1;
          end
          default: ;
        endcase
        if (fin_int) begin
          if (!int_num) begin
            int_num_next = 1'b1;
            phase_next   = PH_INT_TAG;
          end else if (byte_count_next != seq_len) begin
            err_next = 1'b1;
          end else begin
            phase_next = PH_DONE;
          end
        end
      end
      if (last) begin
        cmd.fin          = 1'b1;
        cmd.ok           = !err_next && (phase_next == PH_DONE);
        byte_count_next  = '0;
        seq_len_next     = '0;
        phase_next       = PH_SEQ_TAG;
        int_num_next     = 1'b0;
        bytes_left_next  = '0;
        write_index_next = '0;
        err_next         = 1'b0;
      end
    end
  end

  assign push = accept && (cmd.wr_en || cmd.fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      seq_len     <= '0;
      phase       <= PH_SEQ_TAG;
      int_num     <= 1'b0;
      bytes_left  <= '0;
      write_index <= '0;
      err         <= 1'b0;
    end else begin
      byte_count  <= byte_count_next;
      seq_len     <= seq_len_next;
      phase       <= phase_next;
      int_num     <= int_num_next;
      bytes_left  <= bytes_left_next;
      write_index <= write_index_next;
      err         <= err_next;
    end
  end
endmodule

/* rtl/core/dersig_queue.sv */
// Small FIFO of parser words between front and back.
module dersig_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dersig_pkg::cmd_t push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output dersig_pkg::cmd_t head
);
  import dersig_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end
endmodule

/* rtl/core/dersig_back.sv */
// Signature store and word emitter: applies byte writes, then streams eight words.
module dersig_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  dersig_pkg::cmd_t     q_head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          sig_word,
  output logic [2:0]           word_index,
  output logic                 status,
  output logic                 last_word
);
  import dersig_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_LOAD = 2'd2;
  localparam logic [1:0] B_SEND = 2'd3;

  logic [1:0]             state;
  row_t                   row;
  logic                   ok;
  logic [STORE_BYTES-1:0] vbits;
  logic [LANES-1:0]       vrow;
  logic [7:0]             lane_q [LANES];
  logic [63:0]            word_next;
  logic                   wr_go;

  assign pop   = (state == B_IDLE) && q_valid;
  assign wr_go = pop && q_head.wr_en;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    dersig_ram #(
      .WIDTH(8),
      .DEPTH(ROWS)
    ) u_ram (
      .clk    (clk),
      .we     (wr_go && (q_head.addr[2:0] == 3'(g))),
      .wr_addr(q_head.addr[5:3]),
      .wr_data(q_head.data),
      .rd_addr(row),
      .rd_data(lane_q[g])
    );
  end

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      word_next[63 - 8*j -: 8] = (ok && vrow[j]) ? lane_q[j] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_LOAD) begin
      sig_word   <= word_next;
      word_index <= row;
      status     <= !ok;
      last_word  <= (row == row_t'(ROWS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      row       <= '0;
      ok        <= 1'b0;
      vbits     <= '0;
      vrow      <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (wr_go) begin
            vbits[q_head.addr] <= 1'b1;
          end
          if (pop && q_head.fin) begin
            ok    <= q_head.ok;
            row   <= '0;
            state <= B_READ;
          end
        end
        B_READ: begin
          vrow  <= vbits[{row, 3'b000} +: LANES];
          state <= B_LOAD;
        end
        B_LOAD: begin
          out_valid <= 1'b1;
          state     <= B_SEND;
        end
        B_SEND: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (row == row_t'(ROWS - 1)) begin
              vbits <= '0;
              row   <= '0;
              state <= B_IDLE;
            end else begin
              row   <= row + row_t'(1);
              state <= B_READ;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

/* dv/testbench.sv */
// Self-checking testbench for der_signature_parser_core: directed and random DER streams.
module testbench;
  import dersig_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_BYTES = 45;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 60;
  localparam int DIR_ROWS = 25;

  typedef enum logic [2:0] {
    P_SEQ_TAG, P_SEQ_LEN, P_INT_TAG, P_INT_LEN, P_INT_FIRST, P_INT_BODY, P_DONE
  } der_phase_e;

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  idx;
    logic        st;
    logic        fin;
  } sig_out_t;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       fail;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // lone sequence tag, then a wrong tag
    '{8'h30, 1'b1, 1'b1},
    '{8'hff, 1'b1, 1'b1},
    // two empty integers
    '{8'h30, 1'b0, 1'b0}, '{8'h04, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0},
    // sequence length 71
    '{8'h30, 1'b0, 1'b0}, '{8'h47, 1'b1, 1'b1},
    // r is a dropped zero, s = ff, one trailing byte
    '{8'h30, 1'b0, 1'b0}, '{8'h06, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0}, '{8'hff, 1'b0, 1'b0}, '{8'h11, 1'b1, 1'b0},
    // second integer header runs past the sequence
    '{8'h30, 1'b0, 1'b0}, '{8'h03, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0}, '{8'h02, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b1}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  der_byte;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] sig_word;
  logic [2:0]  word_index;
  logic        status;
  logic        last_word;

  der_signature_parser_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .der_byte   (der_byte),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sig_word   (sig_word),
    .word_index (word_index),
    .status     (status),
    .last_word  (last_word)
  );

  // decoder state
  der_phase_e  phase;
  logic [7:0]  seq_len;
  logic [7:0]  consumed;
  logic        int_sel;
  logic [7:0]  pend;
  logic [5:0]  wr_ptr;
  logic        bad;
  logic [7:0]  sig_bytes [STORE_BYTES];

  sig_out_t    expected_words [$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int bytes_fed;
  int frames_fed;
  int frames_clean;
  int words_seen;
  int mismatches;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_decoder();
    phase    = P_SEQ_TAG;
    seq_len  = '0;
    consumed = '0;
    int_sel  = 1'b0;
    pend     = '0;
    wr_ptr   = '0;
    bad      = 1'b0;
    for (int i = 0; i < STORE_BYTES; i++) sig_bytes[i] = '0;
  endfunction

  function automatic void store_sig_byte(input logic [7:0] b);
    sig_bytes[wr_ptr] = b;
    wr_ptr = wr_ptr + 6'd1;
  endfunction

  function automatic void close_integer();
    if (!int_sel) begin
      int_sel = 1'b1;
      phase = P_INT_TAG;
    end else if (consumed != seq_len) begin
      bad = 1'b1;
    end else begin
      phase = P_DONE;
    end
  endfunction

  function automatic void take_sig_byte(input logic [7:0] b);
    int rem;
    int half_end;
    half_end = int'(INT_BYTES) * (int'(int_sel) + 1);
    case (phase)
      P_SEQ_TAG: begin
        if (b != SEQ_TAG) bad = 1'b1;
        else phase = P_SEQ_LEN;
      end
      P_SEQ_LEN: begin
        if (b > SEQ_MAX) begin
          bad = 1'b1;
        end else begin
          seq_len = b;
          phase = P_INT_TAG;
        end
      end
      P_INT_TAG: begin
        rem = (seq_len >= consumed) ? int'(seq_len) - int'(consumed) : 0;
        consumed = consumed + 8'd1;
        if (rem < 2 || b != INT_TAG) bad = 1'b1;
        else phase = P_INT_LEN;
      end
      P_INT_LEN: begin
        consumed = consumed + 8'd1;
        rem = (seq_len >= consumed) ? int'(seq_len) - int'(consumed) : 0;
        if (int'(b) > rem || b > INT_LEN_MAX) begin
          bad = 1'b1;
        end else if (b == 8'd0) begin
          close_integer();
        end else begin
          pend = b;
          phase = P_INT_FIRST;
        end
      end
      P_INT_FIRST: begin
        consumed = consumed + 8'd1;
        if (b == 8'd0) begin
          pend = pend - 8'd1;
          wr_ptr = 6'(half_end - int'(pend));
          if (pend == 8'd0) close_integer();
          else phase = P_INT_BODY;
        end else if (int'(pend) > int'(INT_BYTES)) begin
          bad = 1'b1;
        end else begin
          wr_ptr = 6'(half_end - int'(pend));
          store_sig_byte(b);
          pend = pend - 8'd1;
          if (pend == 8'd0) close_integer();
          else phase = P_INT_BODY;
        end
      end
      P_INT_BODY: begin
        consumed = consumed + 8'd1;
        store_sig_byte(b);
        pend = pend - 8'd1;
        if (pend == 8'd0) close_integer();
      end
      default: ;
    endcase
  endfunction

  // advance the decoder by one byte; on the final byte queue its eight words
  function automatic void decode_byte(input logic [7:0] b, input logic l,
                                      input logic typed_fail);
    logic     ok;
    sig_out_t w;
    if (!bad) take_sig_byte(b);
    if (l) begin
      ok = !bad && phase == P_DONE;
      for (int k = 0; k < 8; k++) begin
        w.word = '0;
        if (ok && !typed_fail)
          for (int j = 0; j < 8; j++) w.word = {w.word[55:0], sig_bytes[k * 8 + j]};
        w.idx = 3'(k);
        w.st  = typed_fail ? 1'b1 : !ok;
        w.fin = (k == 7);
        expected_words.push_back(w);
      end
      frames_fed++;
      if (ok) frames_clean++;
      clear_decoder();
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic l, input logic typed_fail);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    der_byte <= b;
    last     <= l;
    do @(posedge clk); while (in_stall);
    bytes_fed++;
    decode_byte(b, l, typed_fail);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int pick_int_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return int'(INT_BYTES) + 1;
    if (r < 10) return int'(INT_BYTES);
    return $urandom_range(4);
  endfunction

  task automatic add_integer(ref logic [7:0] m [$], input int n);
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      v = 8'($urandom_range(255));
      if (i == 0 && (n > int'(INT_BYTES) || $urandom_range(4) == 0)) v = 8'h00;
      m.push_back(v);
    end
  endtask

  task automatic send_frame();
    logic [7:0] m [$];
    int kind;
    int lr;
    int ls;
    int cut;
    kind = $urandom_range(99);
    if (kind < 85) begin
      lr = pick_int_len();
      ls = pick_int_len();
      m = {SEQ_TAG, 8'(4 + lr + ls), INT_TAG, 8'(lr)};
      add_integer(m, lr);
      m.push_back(INT_TAG);
      m.push_back(8'(ls));
      add_integer(m, ls);
      if (kind < 70) begin
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(3, 1)) m.push_back(8'($urandom_range(255)));
      end else begin
        case ($urandom_range(3))
          0: begin
            cut = $urandom_range(m.size() - 1, 1);
            while (m.size() > cut) void'(m.pop_back());
          end
          1: m[$urandom_range(m.size() - 1)] = 8'($urandom_range(255));
          2: m[1] = 8'($urandom_range(255));
          default: m[3] = 8'($urandom_range(40));
        endcase
      end
    end else begin
      repeat ($urandom_range(6, 1)) m.push_back(8'($urandom_range(255)));
      if ($urandom_range(1) == 0) m[0] = SEQ_TAG;
    end
    for (int i = 0; i < m.size(); i++) push_byte(m[i], i == m.size() - 1, 1'b0);
  endtask

  // receiver side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    sig_out_t want;
    if (!rst && out_valid && !out_stall) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word %h index %0d status %0d", sig_word, word_index, status);
      end else begin
        want = expected_words.pop_front();
        if (sig_word !== want.word || word_index !== want.idx || status !== want.st ||
            last_word !== want.fin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected %h idx %0d st %0d lw %0d, got %h idx %0d st %0d lw %0d",
                     want.word, want.idx, want.st, want.fin,
                     sig_word, word_index, status, last_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles with no transfer", quiet_cycles);
      $display("der_signature_parser_core verification failed");
      $finish;
    end
  end

  initial begin
    int start;
    rst = 1'b1;
    in_valid = 1'b0;
    der_byte = '0;
    last = 1'b0;
    hold_req = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 69;
    bytes_fed = 0;
    frames_fed = 0;
    frames_clean = 0;
    words_seen = 0;
    mismatches = 0;
    quiet_cycles = 0;
    clear_decoder();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      push_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].l, DIRECTED_ROWS[i].fail);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 6 : (p == 1) ? 69 : 0;
      recv_idle_pct = (p == 0) ? 69 : (p == 1) ? 6 : 0;
      // long output hold while frames keep coming, so the input backs up
      if (p == 2) hold_req = 1'b1;
      start = bytes_fed;
      while (bytes_fed - start < PHASE_BYTES) send_frame();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("fed %0d bytes in %0d frames, %0d decoded cleanly, %0d rejected",
             bytes_fed, frames_fed, frames_clean, frames_fed - frames_clean);
    $display("compared %0d output words under three stall mixes, %0d mismatches",
             words_seen, mismatches);
    if (mismatches == 0) begin
      $display("der_signature_parser_core verification clean");
    end else begin
      $display("der_signature_parser_core verification failed");
    end
    $finish;
  end

endmodule
